// ----- hw/rtl/clkta_pkg.sv -----
// ----------------------------------------------------------------------------
// clkta_pkg
// Types, request codes, divider constants and the seven-segment table that
// the time of day adjust and display block uses.
// ----------------------------------------------------------------------------
package clkta_pkg;

    localparam logic [2:0] REQ_ADD_MIN = 3'd0;
    localparam logic [2:0] REQ_SUB_MIN = 3'd1;
    localparam logic [2:0] REQ_ADD_HR  = 3'd2;
    localparam logic [2:0] REQ_SUB_HR  = 3'd3;
    localparam logic [2:0] REQ_SET     = 3'd4;

    localparam logic [5:0] MIN_PER_HOUR = 6'd60;
    localparam logic [4:0] HR_PER_DAY   = 5'd24;
    localparam logic [3:0] DEC_BASE     = 4'd10;

    // Reciprocals for the constant dividers: x / 60 = (x * RECIP_60) >> 22,
    // x / 24 = (x * RECIP_24) >> 20 for 16-bit x, and q / 24 =
    // (q * RECIP_24_Q) >> 16 for q up to 1092.
    localparam logic [16:0] RECIP_60   = 17'd69906;
    localparam logic [15:0] RECIP_24   = 16'd43691;
    localparam logic [11:0] RECIP_24_Q = 12'd2731;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] amount;
        logic [4:0]  set_hours;
        logic [5:0]  set_minutes;
    } t_req_item;

    typedef struct packed {
        logic [4:0] hours_now;
        logic [5:0] minutes_now;
        logic [1:0] hour_tens;
        logic [3:0] hour_units;
        logic [2:0] minute_tens;
        logic [3:0] minute_units;
        logic [6:0] seg_hour_tens;
        logic [6:0] seg_hour_units;
        logic [6:0] seg_minute_tens;
        logic [6:0] seg_minute_units;
        logic       set_error;
    } t_time_item;

    typedef struct packed {
        logic [2:0] req_type;
        logic [4:0] set_hours;
        logic [5:0] set_minutes;
        logic [5:0] min_rem;
        logic [4:0] min_hours;
        logic [4:0] hr_rem;
    } t_red_item;

    function automatic logic [6:0] seg7(input logic [3:0] digit);
        logic [6:0] pattern;
        case (digit)
            4'd0: pattern = 7'h77;
            4'd1: pattern = 7'h24;
            4'd2: pattern = 7'h5D;
            4'd3: pattern = 7'h6D;
            4'd4: pattern = 7'h2E;
            4'd5: pattern = 7'h6B;
            4'd6: pattern = 7'h7B;
            4'd7: pattern = 7'h25;
            4'd8: pattern = 7'h7F;
            4'd9: pattern = 7'h6F;
            default: pattern = 7'h00;
        endcase
        return pattern;
    endfunction

endpackage

// ----- hw/rtl/clock_time_adjust_display.sv -----
// ----------------------------------------------------------------------------
// clock_time_adjust_display
// 24-hour time of day with set, add and subtract requests, returning the
// time, its decimal digits and seven-segment patterns after each request.
// ----------------------------------------------------------------------------
// The block accepts one request transaction per clock cycle while o_stall
// is low. It returns one result transaction per request, in order. A request
// passes through the four reduce registers and then the result register.
// Up to five transactions are held inside, so a stalled output stalls the
// input only once all five are full. Four register stages reduce the
// request count with constant-reciprocal multiplies, with no more than one
// multiply between any two registers. The final stage applies the adjust to
// the time register and fills the result register in the same cycle, which
// is what allows back-to-back requests.
module clock_time_adjust_display (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  clkta_pkg::t_req_item  i_data,
    output logic                  o_stall,
    output logic                  o_valid,
    output clkta_pkg::t_time_item o_data,
    input  logic                  i_stall
);

    logic                 w_in_ready;
    logic                 w_red_valid;
    logic                 w_red_ready;
    clkta_pkg::t_red_item w_red_item;

    clkta_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_ready (w_in_ready),
        .o_valid (w_red_valid),
        .o_data  (w_red_item),
        .i_ready (w_red_ready)
    );

    clkta_update u_update (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_red_valid),
        .i_data  (w_red_item),
        .o_ready (w_red_ready),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    assign o_stall = !w_in_ready;

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.hours_now < 5'd24 && o_data.minutes_now < 6'd60))
        else $error("Result time is out of range.");

    a_error_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.set_error) |->
            (o_data.hours_now == 5'd0 && o_data.minutes_now == 6'd0))
        else $error("Set error without a cleared time.");

    a_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (5'(o_data.hour_tens) * 5'd10 + 5'(o_data.hour_units)
                         == o_data.hours_now
                     && 6'(o_data.minute_tens) * 6'd10 + 6'(o_data.minute_units)
                         == o_data.minutes_now))
        else $error("Decimal digits do not match the time.");

endmodule

// ----- hw/rtl/clkta_reduce.sv -----
// ----------------------------------------------------------------------------
// clkta_reduce
// Pipeline that reduces the request count: minutes modulo 60, whole hours
// carried by the minutes modulo 24, and hours modulo 24.
// ----------------------------------------------------------------------------
module clkta_reduce (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  clkta_pkg::t_req_item  i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output clkta_pkg::t_red_item  o_data,
    input  logic                  i_ready
);

    logic                 r_a_valid;
    clkta_pkg::t_req_item r_a_item;

    logic        r_b_valid;
    logic [2:0]  r_b_req;
    logic [4:0]  r_b_sh;
    logic [5:0]  r_b_sm;
    logic [15:0] r_b_amount;
    logic [10:0] r_b_q60;
    logic [11:0] r_b_q24;

    logic        r_c_valid;
    logic [2:0]  r_c_req;
    logic [4:0]  r_c_sh;
    logic [5:0]  r_c_sm;
    logic [5:0]  r_c_min_rem;
    logic [4:0]  r_c_hr_rem;
    logic [10:0] r_c_q60;
    logic [5:0]  r_c_qq;

    logic                 r_d_valid;
    clkta_pkg::t_red_item r_d_item;

    logic        w_ready_a;
    logic        w_ready_b;
    logic        w_ready_c;
    logic        w_ready_d;
    logic [32:0] w_prod60;
    logic [31:0] w_prod24;
    logic [15:0] w_min_rem;
    logic [15:0] w_hr_rem;
    logic [22:0] w_prod_q;
    logic [10:0] w_min_hours;

    assign w_ready_d = !r_d_valid || i_ready;
    assign w_ready_c = !r_c_valid || w_ready_d;
    assign w_ready_b = !r_b_valid || w_ready_c;
    assign w_ready_a = !r_a_valid || w_ready_b;
    assign o_ready   = w_ready_a;

    assign w_prod60 = 33'(r_a_item.amount) * 33'(clkta_pkg::RECIP_60);
    assign w_prod24 = 32'(r_a_item.amount) * 32'(clkta_pkg::RECIP_24);

    assign w_min_rem = r_b_amount - 16'(r_b_q60) * 16'(clkta_pkg::MIN_PER_HOUR);
    assign w_hr_rem  = r_b_amount - 16'(r_b_q24) * 16'(clkta_pkg::HR_PER_DAY);
    assign w_prod_q  = 23'(r_b_q60) * 23'(clkta_pkg::RECIP_24_Q);

    assign w_min_hours = r_c_q60 - 11'(r_c_qq) * 11'(clkta_pkg::HR_PER_DAY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (w_ready_a) begin
                r_a_valid <= i_valid;
            end
            if (w_ready_b) begin
                r_b_valid <= r_a_valid;
            end
            if (w_ready_c) begin
                r_c_valid <= r_b_valid;
            end
            if (w_ready_d) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_a_item <= i_data;
        end
        if (w_ready_b && r_a_valid) begin
            r_b_req    <= r_a_item.req_type;
            r_b_sh     <= r_a_item.set_hours;
            r_b_sm     <= r_a_item.set_minutes;
            r_b_amount <= r_a_item.amount;
            r_b_q60    <= w_prod60[32:22];
            r_b_q24    <= w_prod24[31:20];
        end
        if (w_ready_c && r_b_valid) begin
            r_c_req     <= r_b_req;
            r_c_sh      <= r_b_sh;
            r_c_sm      <= r_b_sm;
            r_c_min_rem <= w_min_rem[5:0];
            r_c_hr_rem  <= w_hr_rem[4:0];
            r_c_q60     <= r_b_q60;
            r_c_qq      <= w_prod_q[21:16];
        end
        if (w_ready_d && r_c_valid) begin
            r_d_item.req_type    <= r_c_req;
            r_d_item.set_hours   <= r_c_sh;
            r_d_item.set_minutes <= r_c_sm;
            r_d_item.min_rem     <= r_c_min_rem;
            r_d_item.min_hours   <= w_min_hours[4:0];
            r_d_item.hr_rem      <= r_c_hr_rem;
        end
    end

    assign o_valid = r_d_valid;
    assign o_data  = r_d_item;

endmodule

// ----- hw/rtl/clkta_update.sv -----
// ----------------------------------------------------------------------------
// clkta_update
// Time of day register, the adjust step applied to it, digit split and
// segment encoding, and the result register.
// ----------------------------------------------------------------------------
module clkta_update (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  clkta_pkg::t_red_item  i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output clkta_pkg::t_time_item o_data,
    input  logic                  i_stall
);

    logic                  r_valid;
    logic [4:0]            r_hour;
    logic [5:0]            r_min;
    clkta_pkg::t_time_item r_out;

    logic [4:0]            n_hour;
    logic [5:0]            n_min;
    logic                  w_err;
    logic [1:0]            w_ht;
    logic [3:0]            w_hu;
    logic [2:0]            w_mt;
    logic [3:0]            w_mu;
    logic                  w_ready;

    assign w_ready = !r_valid || !i_stall;
    assign o_ready = w_ready;

    always_comb begin
        logic [6:0] msum;
        logic [5:0] hsum;
        logic [5:0] hdec;
        logic       carry;
        msum   = 7'd0;
        hsum   = 6'(r_hour);
        hdec   = 6'd0;
        carry  = 1'b0;
        n_hour = r_hour;
        n_min  = r_min;
        w_err  = 1'b0;
        case (i_data.req_type)
            clkta_pkg::REQ_ADD_MIN: begin
                msum  = 7'(r_min) + 7'(i_data.min_rem);
                carry = msum >= 7'(clkta_pkg::MIN_PER_HOUR);
                n_min = carry ? 6'(msum - 7'(clkta_pkg::MIN_PER_HOUR)) : msum[5:0];
                hsum  = 6'(r_hour) + 6'(i_data.min_hours) + 6'(carry);
            end
            clkta_pkg::REQ_SUB_MIN: begin
                carry = r_min < i_data.min_rem;
                msum  = 7'(r_min) + (carry ? 7'(clkta_pkg::MIN_PER_HOUR) : 7'd0)
                        - 7'(i_data.min_rem);
                n_min = msum[5:0];
                hdec  = 6'(i_data.min_hours) + 6'(carry);
                hsum  = 6'(r_hour) + 6'(clkta_pkg::HR_PER_DAY) - hdec;
            end
            clkta_pkg::REQ_ADD_HR: begin
                hsum = 6'(r_hour) + 6'(i_data.hr_rem);
            end
            clkta_pkg::REQ_SUB_HR: begin
                hsum = 6'(r_hour) + 6'(clkta_pkg::HR_PER_DAY) - 6'(i_data.hr_rem);
            end
            clkta_pkg::REQ_SET: begin
                if (i_data.set_hours >= clkta_pkg::HR_PER_DAY
                    || i_data.set_minutes >= clkta_pkg::MIN_PER_HOUR) begin
                    hsum  = 6'd0;
                    n_min = 6'd0;
                    w_err = 1'b1;
                end else begin
                    hsum  = 6'(i_data.set_hours);
                    n_min = i_data.set_minutes;
                end
            end
            default: begin
                hsum = 6'(r_hour);
            end
        endcase
        n_hour = (hsum >= 6'(clkta_pkg::HR_PER_DAY))
               ? 5'(hsum - 6'(clkta_pkg::HR_PER_DAY)) : hsum[4:0];
    end

    always_comb begin
        if (n_hour >= 5'd20) begin
            w_ht = 2'd2;
        end else if (n_hour >= 5'(clkta_pkg::DEC_BASE)) begin
            w_ht = 2'd1;
        end else begin
            w_ht = 2'd0;
        end
        if (n_min >= 6'd50) begin
            w_mt = 3'd5;
        end else if (n_min >= 6'd40) begin
            w_mt = 3'd4;
        end else if (n_min >= 6'd30) begin
            w_mt = 3'd3;
        end else if (n_min >= 6'd20) begin
            w_mt = 3'd2;
        end else if (n_min >= 6'(clkta_pkg::DEC_BASE)) begin
            w_mt = 3'd1;
        end else begin
            w_mt = 3'd0;
        end
        w_hu = 4'(n_hour - 5'(w_ht) * 5'(clkta_pkg::DEC_BASE));
        w_mu = 4'(n_min - 6'(w_mt) * 6'(clkta_pkg::DEC_BASE));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hour  <= 5'd0;
            r_min   <= 6'd0;
        end else if (w_ready) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_hour <= n_hour;
                r_min  <= n_min;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_out.hours_now        <= n_hour;
            r_out.minutes_now      <= n_min;
            r_out.hour_tens        <= w_ht;
            r_out.hour_units       <= w_hu;
            r_out.minute_tens      <= w_mt;
            r_out.minute_units     <= w_mu;
            r_out.seg_hour_tens    <= clkta_pkg::seg7(4'(w_ht));
            r_out.seg_hour_units   <= clkta_pkg::seg7(w_hu);
            r_out.seg_minute_tens  <= clkta_pkg::seg7(4'(w_mt));
            r_out.seg_minute_units <= clkta_pkg::seg7(w_mu);
            r_out.set_error        <= w_err;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

endmodule

// ----- tb/clock_time_adjust_display_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_time_adjust_display_checker
// Watches the request and time channels of the time of day block. It keeps
// its own copy of the clock and works out the expected time transaction
// for every accepted request. It compares each accepted time transaction,
// field by field, with the oldest expected one, and counts mismatches.
// ----------------------------------------------------------------------------
module clock_time_adjust_display_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  clkta_pkg::t_req_item  i_req,
    input  logic                  i_req_stall,
    input  logic                  i_time_valid,
    input  clkta_pkg::t_time_item i_time,
    input  logic                  i_time_stall,
    output int                    o_mismatches,
    output int                    o_pending
);

    localparam int MINUTES_PER_HOUR = clkta_pkg::MIN_PER_HOUR;
    localparam int HOURS_PER_DAY    = clkta_pkg::HR_PER_DAY;
    localparam int DIGIT_BASE       = clkta_pkg::DEC_BASE;

    int                    clock_hours;
    int                    clock_minutes;
    clkta_pkg::t_time_item expected_times[$];
    clkta_pkg::t_time_item oldest_time;

    function automatic logic [6:0] digit_segments(input int digit);
        logic [6:0] lit;
        case (digit)
            0: lit = 7'h77;
            1: lit = 7'h24;
            2: lit = 7'h5D;
            3: lit = 7'h6D;
            4: lit = 7'h2E;
            5: lit = 7'h6B;
            6: lit = 7'h7B;
            7: lit = 7'h25;
            8: lit = 7'h7F;
            9: lit = 7'h6F;
            default: lit = 7'h00;
        endcase
        return lit;
    endfunction

    function automatic clkta_pkg::t_time_item advance_clock(input clkta_pkg::t_req_item req);
        int                    hrs;
        int                    mins;
        int                    total;
        int                    part_hour;
        int                    whole_hours;
        logic                  bad_set;
        clkta_pkg::t_time_item shown;
        hrs     = clock_hours;
        mins    = clock_minutes;
        bad_set = 1'b0;
        case (req.req_type)
            clkta_pkg::REQ_ADD_MIN: begin
                total = mins + int'(req.amount);
                mins  = total % MINUTES_PER_HOUR;
                hrs   = (hrs + (total / MINUTES_PER_HOUR) % HOURS_PER_DAY) % HOURS_PER_DAY;
            end
            clkta_pkg::REQ_SUB_MIN: begin
                part_hour   = int'(req.amount) % MINUTES_PER_HOUR;
                whole_hours = int'(req.amount) / MINUTES_PER_HOUR;
                if (mins < part_hour) begin
                    mins = mins + MINUTES_PER_HOUR - part_hour;
                    hrs  = (hrs + HOURS_PER_DAY - 1) % HOURS_PER_DAY;
                end else begin
                    mins = mins - part_hour;
                end
                hrs = (hrs + HOURS_PER_DAY - whole_hours % HOURS_PER_DAY) % HOURS_PER_DAY;
            end
            clkta_pkg::REQ_ADD_HR: begin
                hrs = (hrs + int'(req.amount) % HOURS_PER_DAY) % HOURS_PER_DAY;
            end
            clkta_pkg::REQ_SUB_HR: begin
                hrs = (hrs + HOURS_PER_DAY - int'(req.amount) % HOURS_PER_DAY) % HOURS_PER_DAY;
            end
            clkta_pkg::REQ_SET: begin
                if (int'(req.set_hours) >= HOURS_PER_DAY ||
                    int'(req.set_minutes) >= MINUTES_PER_HOUR) begin
                    hrs     = 0;
                    mins    = 0;
                    bad_set = 1'b1;
                end else begin
                    hrs  = int'(req.set_hours);
                    mins = int'(req.set_minutes);
                end
            end
            default: begin
            end
        endcase
        clock_hours   = hrs;
        clock_minutes = mins;

        shown.hours_now        = 5'(hrs);
        shown.minutes_now      = 6'(mins);
        shown.hour_tens        = 2'(hrs / DIGIT_BASE);
        shown.hour_units       = 4'(hrs % DIGIT_BASE);
        shown.minute_tens      = 3'(mins / DIGIT_BASE);
        shown.minute_units     = 4'(mins % DIGIT_BASE);
        shown.seg_hour_tens    = digit_segments(hrs / DIGIT_BASE);
        shown.seg_hour_units   = digit_segments(hrs % DIGIT_BASE);
        shown.seg_minute_tens  = digit_segments(mins / DIGIT_BASE);
        shown.seg_minute_units = digit_segments(mins % DIGIT_BASE);
        shown.set_error        = bad_set;
        return shown;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clock_hours   = 0;
            clock_minutes = 0;
            expected_times.delete();
        end else begin
            if (i_req_valid && !i_req_stall) begin
                expected_times.push_back(advance_clock(i_req));
            end
            if (i_time_valid && !i_time_stall) begin
                if (expected_times.size() == 0) begin
                    $error("time transaction arrived with no request outstanding");
                    o_mismatches++;
                end else begin
                    oldest_time = expected_times.pop_front();
                    compare_field("hours_now", oldest_time.hours_now, i_time.hours_now);
                    compare_field("minutes_now", oldest_time.minutes_now,
                                  i_time.minutes_now);
                    compare_field("hour_tens", oldest_time.hour_tens, i_time.hour_tens);
                    compare_field("hour_units", oldest_time.hour_units, i_time.hour_units);
                    compare_field("minute_tens", oldest_time.minute_tens,
                                  i_time.minute_tens);
                    compare_field("minute_units", oldest_time.minute_units,
                                  i_time.minute_units);
                    compare_field("seg_hour_tens", oldest_time.seg_hour_tens,
                                  i_time.seg_hour_tens);
                    compare_field("seg_hour_units", oldest_time.seg_hour_units,
                                  i_time.seg_hour_units);
                    compare_field("seg_minute_tens", oldest_time.seg_minute_tens,
                                  i_time.seg_minute_tens);
                    compare_field("seg_minute_units", oldest_time.seg_minute_units,
                                  i_time.seg_minute_units);
                    compare_field("set_error", oldest_time.set_error, i_time.set_error);
                end
            end
        end
        o_pending = expected_times.size();
    end

endmodule

// ----- tb/clock_time_adjust_display_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_time_adjust_display_tb
// Drives set, add and subtract requests into the time of day block: a
// directed run over the field extremes, midnight wrap, borrows and bad set
// values, then random requests with random gaps and output stalls, including
// one long output hold-off. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module clock_time_adjust_display_tb;

    localparam int         CLK_PERIOD        = 20;
    localparam int         RESET_CYCLES      = 10;
    localparam int         RANDOM_REQUESTS   = 1600;
    localparam int         FLOOD_REQUESTS    = 150;
    localparam int         HOLD_OFF_CYCLES   = 400;
    localparam int         DRAIN_CYCLES      = 20;
    localparam int         CYCLE_LIMIT       = 1000000;
    localparam logic [2:0] REQ_UNUSED_FIRST  = 3'd5;
    localparam logic [2:0] REQ_UNUSED_MID    = 3'd6;
    localparam logic [2:0] REQ_UNUSED_LAST   = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    clkta_pkg::t_req_item  req_data = '0;
    logic                  req_stall;
    logic                  time_valid;
    clkta_pkg::t_time_item time_data;
    logic                  time_stall = 1'b0;
    logic                  flood_on = 1'b0;
    int                    mismatches;
    int                    pending;
    int                    cycle_count = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    clock_time_adjust_display i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (req_valid),
        .i_data  (req_data),
        .o_stall (req_stall),
        .o_valid (time_valid),
        .o_data  (time_data),
        .i_stall (time_stall)
    );

    clock_time_adjust_display_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req        (req_data),
        .i_req_stall  (req_stall),
        .i_time_valid (time_valid),
        .i_time       (time_data),
        .i_time_stall (time_stall),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic clkta_pkg::t_req_item make_request(input logic [2:0] code,
                                                          input logic [15:0] amt,
                                                          input logic [4:0] hrs,
                                                          input logic [5:0] mins);
        clkta_pkg::t_req_item req;
        req.req_type    = code;
        req.amount      = amt;
        req.set_hours   = hrs;
        req.set_minutes = mins;
        return req;
    endfunction

    function automatic clkta_pkg::t_req_item random_request();
        clkta_pkg::t_req_item req;
        int                   roll;
        roll = $urandom_range(0, 99);
        if (roll < 19) req.req_type = clkta_pkg::REQ_ADD_MIN;
        else if (roll < 38) req.req_type = clkta_pkg::REQ_SUB_MIN;
        else if (roll < 55) req.req_type = clkta_pkg::REQ_ADD_HR;
        else if (roll < 72) req.req_type = clkta_pkg::REQ_SUB_HR;
        else if (roll < 95) req.req_type = clkta_pkg::REQ_SET;
        else req.req_type = 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
        roll = $urandom_range(0, 9);
        if (roll < 5) req.amount = 16'($urandom_range(0, 150));
        else if (roll < 7) req.amount = 16'($urandom_range(0, 1500));
        else req.amount = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 4) != 0) begin
            req.set_hours   = 5'($urandom_range(0, 23));
            req.set_minutes = 6'($urandom_range(0, 59));
        end else begin
            req.set_hours   = 5'($urandom_range(0, 31));
            req.set_minutes = 6'($urandom_range(0, 63));
        end
        return req;
    endfunction

    task automatic send_request(input clkta_pkg::t_req_item req, input int gap);
        logic taken;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= req;
        do begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end while (!taken);
    endtask

    task automatic output_idle_spell();
        int hold;
        hold = pick_gap();
        if (hold > 0) begin
            time_stall <= 1'b1;
            repeat (hold) @(posedge clk);
        end
        time_stall <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 150)) @(posedge clk);
        else repeat ($urandom_range(1, 8)) @(posedge clk);
    endtask

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        wait (rst_n);
        @(posedge clk);
        while (!flood_on) output_idle_spell();
        time_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        forever output_idle_spell();
    end

    initial begin
        int gap;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_request(clkta_pkg::REQ_SET, 16'd0, 5'd23, 6'd59), pick_gap());
        send_request(make_request(clkta_pkg::REQ_ADD_MIN, 16'd1, 5'd0, 6'd0), pick_gap());
        send_request(make_request(clkta_pkg::REQ_SUB_MIN, 16'd1, 5'd0, 6'd0), pick_gap());
        send_request(make_request(clkta_pkg::REQ_ADD_MIN, 16'd0, 5'd31, 6'd63), pick_gap());
        send_request(make_request(clkta_pkg::REQ_ADD_MIN, 16'hFFFF, 5'd0, 6'd0), pick_gap());
        send_request(make_request(clkta_pkg::REQ_SUB_MIN, 16'hFFFF, 5'd0, 6'd0), pick_gap());
        send_request(make_request(clkta_pkg::REQ_SET, 16'd0, 5'd0, 6'd0), pick_gap());
        send_request(make_request(clkta_pkg::REQ_SUB_MIN, 16'd60, 5'd0, 6'd0), pick_gap());
        send_request(make_request(clkta_pkg::REQ_ADD_HR, 16'hFFFF, 5'd0, 6'd0), pick_gap());
        send_request(make_request(clkta_pkg::REQ_SUB_HR, 16'hFFFF, 5'd0, 6'd0), pick_gap());
        send_request(make_request(clkta_pkg::REQ_ADD_HR, 16'd23, 5'd0, 6'd0), pick_gap());
        send_request(make_request(clkta_pkg::REQ_SUB_HR, 16'd0, 5'd0, 6'd0), pick_gap());
        send_request(make_request(clkta_pkg::REQ_SET, 16'd0, 5'd24, 6'd0), pick_gap());
        send_request(make_request(clkta_pkg::REQ_SET, 16'd0, 5'd10, 6'd60), pick_gap());
        send_request(make_request(clkta_pkg::REQ_SET, 16'hFFFF, 5'd31, 6'd63), pick_gap());
        send_request(make_request(clkta_pkg::REQ_SET, 16'd0, 5'd19, 6'd45), pick_gap());
        send_request(make_request(REQ_UNUSED_FIRST, 16'hFFFF, 5'd0, 6'd0), pick_gap());
        send_request(make_request(REQ_UNUSED_MID, 16'd100, 5'd12, 6'd30), pick_gap());
        send_request(make_request(REQ_UNUSED_LAST, 16'hFFFF, 5'd31, 6'd63), pick_gap());
        send_request(make_request(clkta_pkg::REQ_SUB_MIN, 16'd46, 5'd0, 6'd0), pick_gap());
        send_request(make_request(clkta_pkg::REQ_SET, 16'd0, 5'd20, 6'd0), pick_gap());
        send_request(make_request(clkta_pkg::REQ_SUB_HR, 16'd21, 5'd0, 6'd0), pick_gap());
        send_request(make_request(clkta_pkg::REQ_ADD_MIN, 16'd1439, 5'd0, 6'd0), pick_gap());
        send_request(make_request(clkta_pkg::REQ_SET, 16'd0, 5'd9, 6'd8), pick_gap());

        flood_on = 1'b1;
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i < FLOOD_REQUESTS || (i / 200) % 4 == 3) gap = 0;
            else gap = pick_gap();
            send_request(random_request(), gap);
        end
        req_valid <= 1'b0;

        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/clkta_pkg.sv
hw/rtl/clkta_reduce.sv
hw/rtl/clkta_update.sv
hw/rtl/clock_time_adjust_display.sv
tb/clock_time_adjust_display_checker.sv
tb/clock_time_adjust_display_tb.sv
